// ===== rtl/edit_script_run_merger_assert.svh =====
// Assertion macros for the edit script run merger.
// Used by modules that own clk and rst_n; needs no package.
`ifndef EDIT_SCRIPT_RUN_MERGER_ASSERT_SVH
`define EDIT_SCRIPT_RUN_MERGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ERM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ERM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/erm_pkg.sv =====
// Shared types and constants for the edit script run merger.
// No dependencies; imported by the output register, the top level and the testbench.
`default_nettype none

package erm_pkg;

  localparam int MAX_RUN_DEF = 32;
  localparam int CNT_W       = 6;

  localparam logic [2:0] CMD_SAME   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_SUBST  = 3'd3;
  localparam logic [2:0] CMD_END    = 3'd4;

  localparam logic [31:0] DELETE_MARK = 32'd45;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] edit_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] out_value;
    logic        run_overflow;
    logic        last_result;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TAIL
  } erm_state_t;

endpackage

`default_nettype wire

// ===== rtl/erm_char_buf.sv =====
// Insert character buffer: one write port, one registered read port.
// Depends on nothing but its parameter.
`default_nettype none

module erm_char_buf #(
  parameter int MAX_RUN = 32,
  parameter int IDX_W   = 5
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [7:0]       rd_data
);

  logic [7:0] mem [0:MAX_RUN-1];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Addresses past the depth are never issued by the replay index, which
  // stays below the run length; fold them to entry zero.
  always_ff @(posedge clk) begin
    if ({1'b0, rd_addr} < (IDX_W + 1)'(MAX_RUN)) begin
      rd_data_r <= mem[rd_addr];
    end else begin
      rd_data_r <= mem[0];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/erm_out_reg.sv =====
// Output register stage of the run merger: holds one result word.
// Depends on erm_pkg for the result word type.
`default_nettype none

module erm_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              emit_valid,
  input  wire erm_pkg::out_word_t emit_word,
  output logic                   emit_ready,
  output logic                   out_valid,
  output erm_pkg::out_word_t     out_data,
  input  wire logic              out_ready
);

  import erm_pkg::*;

  logic      full_r;
  logic      full_nxt;
  out_word_t data_r;

  // Take a new word when empty or when the held word leaves this cycle.
  assign emit_ready = !full_r || out_ready;

  always_comb begin
    full_nxt = full_r;
    if (emit_valid && emit_ready) begin
      full_nxt = 1'b1;
    end else if (out_ready) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      data_r <= emit_word;
    end
  end

  assign out_valid = full_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ===== rtl/edit_script_run_merger.sv =====
// Edit script run merger, top level.
//
// Input channel in_valid/in_ready/in_data carries edit words (same, insert,
// delete, substitution, end of script). Result channel out_valid/out_ready/
// out_data carries result words through a one-word output register.
// Insert, delete, substitution and unknown words are taken one per cycle:
// inserts write their character into the buffer memory, deletes and
// substitutions bump a counter, and none of them yields a result.
// A same or end word closes the run. After it is taken the block stops
// accepting and replays the run, one result word per cycle from the
// buffer memory read port: min(ins,del) substitutions, then the leftover
// inserts or deletes. Then it sends the same word through, or for end of
// script the distance total, which is cleared afterwards.
// Such a word keeps the input closed until the replay and the closing result
// have been handed to the output register; the first result passes through
// the state register and the output register before it shows. The single
// buffer read port sets the one word per cycle replay rate.
// A stalled receiver holds the output register and freezes the replay; no
// word is lost. Reset (rst_n low, synchronous) clears counters, flags,
// distance and the output register's valid flag; buffer contents need no
// clearing since only entries written in the current run are used.
`default_nettype none

module edit_script_run_merger #(
  parameter int MAX_RUN = erm_pkg::MAX_RUN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire erm_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output erm_pkg::out_word_t      out_data
);

  import erm_pkg::*;

  localparam int IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  erm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] ins_r, ins_nxt;
  logic [CNT_W-1:0] del_r, del_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic [31:0]      dist_r, dist_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [31:0]      val_r, val_nxt;

  logic [CNT_W-1:0] subs;
  logic [CNT_W-1:0] most;
  logic [32:0]      dist_sum;
  logic             in_take;
  logic             wr_en;
  logic [7:0]       rd_char;
  logic             emit_valid;
  logic             emit_ready;
  out_word_t        emit_word;
  logic             counts_ok;
  logic             run_clear;
  logic             flush_last;
  logic             report_done;

  assign subs     = (ins_r < del_r) ? ins_r : del_r;
  assign most     = (ins_r > del_r) ? ins_r : del_r;
  assign dist_sum = {1'b0, dist_r} + 33'(most);

  assign in_ready = (state_r == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign wr_en    = in_take && (in_data.command == CMD_INSERT) &&
                    (ins_r < CNT_W'(MAX_RUN));

  // Buffer read address follows the next replay index, so the read data
  // always lines up with idx_r. Writes happen only while idle, and the
  // first replay read is issued in the accept cycle of the closing word,
  // which never writes.
  erm_char_buf #(
    .MAX_RUN (MAX_RUN),
    .IDX_W   (IDX_W)
  ) u_char_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ins_r[IDX_W-1:0]),
    .wr_data (in_data.edit_value[7:0]),
    .rd_addr (idx_nxt[IDX_W-1:0]),
    .rd_data (rd_char)
  );

  always_comb begin
    state_nxt  = state_r;
    ins_nxt    = ins_r;
    del_nxt    = del_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    dist_nxt   = dist_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    emit_valid = 1'b0;
    emit_word  = '0;

    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_take) begin
          case (in_data.command)
            CMD_INSERT: begin
              if (ins_r < CNT_W'(MAX_RUN)) begin
                ins_nxt = ins_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_DELETE, CMD_SUBST: begin
              if (del_r < CNT_W'(MAX_RUN)) begin
                del_nxt = del_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_SAME, CMD_END: begin
              // Close the run: fold it into the distance, then replay it.
              dist_nxt  = dist_sum[32] ? '1 : dist_sum[31:0];
              cmd_nxt   = in_data.command;
              val_nxt   = in_data.edit_value;
              state_nxt = (most == '0) ? ST_TAIL : ST_FLUSH;
            end
            default: begin
              // Drop unknown commands.
            end
          endcase
        end
      end

      ST_FLUSH: begin
        emit_valid             = 1'b1;
        emit_word.run_overflow = ovf_r;
        emit_word.last_result  = 1'b0;
        if (idx_r < subs) begin
          emit_word.out_kind  = CMD_SUBST;
          emit_word.out_value = {24'd0, rd_char};
        end else if (ins_r > del_r) begin
          emit_word.out_kind  = CMD_INSERT;
          emit_word.out_value = {24'd0, rd_char};
        end else begin
          emit_word.out_kind  = CMD_DELETE;
          emit_word.out_value = DELETE_MARK;
        end
        if (emit_ready) begin
          if (idx_r == most - 1'b1) begin
            idx_nxt   = '0;
            ins_nxt   = '0;
            del_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_TAIL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_TAIL: begin
        emit_valid            = 1'b1;
        emit_word.last_result = 1'b1;
        if (cmd_r == CMD_END) begin
          emit_word.out_kind  = CMD_END;
          emit_word.out_value = dist_r;
        end else begin
          emit_word.out_kind  = CMD_SAME;
          emit_word.out_value = val_r;
        end
        // Runs with nothing gathered arrive here with counts still zero.
        ins_nxt = '0;
        del_nxt = '0;
        ovf_nxt = 1'b0;
        if (emit_ready) begin
          if (cmd_r == CMD_END) begin
            dist_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ins_r   <= '0;
      del_r   <= '0;
      idx_r   <= '0;
      ovf_r   <= 1'b0;
      dist_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ins_r   <= ins_nxt;
      del_r   <= del_nxt;
      idx_r   <= idx_nxt;
      ovf_r   <= ovf_nxt;
      dist_r  <= dist_nxt;
    end
  end

  // Held closing word: payload only.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
  end

  erm_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_word  (emit_word),
    .emit_ready (emit_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

  assign counts_ok   = (ins_r <= CNT_W'(MAX_RUN)) && (del_r <= CNT_W'(MAX_RUN));
  assign run_clear   = (ins_r == '0) && (del_r == '0);
  assign flush_last  = (state_r == ST_FLUSH) && emit_ready && (idx_r == most - 1'b1);
  assign report_done = (state_r == ST_TAIL) && (cmd_r == CMD_END) && emit_ready;

`include "edit_script_run_merger_assert.svh"

  `ERM_ASSERT_NOW(a_counts_bounded, 1'b1, counts_ok, "run counter past buffer depth")
  `ERM_ASSERT_NOW(a_flush_index, state_r == ST_FLUSH, idx_r < most, "replay index past run")
  `ERM_ASSERT_NEXT(a_flush_done, flush_last, (state_r == ST_TAIL) && run_clear, "run not cleared")
  `ERM_ASSERT_NEXT(a_report_clears, report_done, dist_r == '0, "distance not cleared")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for edit_script_run_merger: drives edit words, predicts the merged
// result words and checks them in order. Depends on erm_pkg and the block RTL.

module tb;
  import erm_pkg::*;

  localparam int          RUN_DEPTH     = erm_pkg::MAX_RUN_DEF;
  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;  // commands above end of script
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
  localparam int          STALL_LIMIT   = 2000;  // cycles with no word moving
  localparam int          DRAIN_CYCLES  = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  edit_script_run_merger i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Idle rates in percent, changed between phases of the run.
  int send_idle_pct;
  int recv_idle_pct;

  // Bookkeeping for the summary and the final verdict.
  int err_count;
  int edit_words;
  int results_checked;
  int overflow_runs;
  int idle_cycles;

  // Predictor state: mirrors the run buffer, counters and distance total.
  logic [7:0]  run_chars [RUN_DEPTH];
  logic [5:0]  run_inserts;
  logic [5:0]  run_deletes;
  logic [31:0] script_distance;
  logic        run_overflowed;

  // Result words still owed by the block, oldest first.
  out_word_t pending_results[$];

  // Append one predicted result word; last_result is patched in afterwards.
  task automatic add_result(logic [2:0] kind, logic [31:0] value, logic ovf);
    out_word_t r;
    r.out_kind     = kind;
    r.out_value    = value;
    r.run_overflow = ovf;
    r.last_result  = 1'b0;
    pending_results = {pending_results, r};
  endtask

  // Replay the gathered run as substitutions, then leftover inserts or
  // deletes, and fold its length into the saturating distance.
  task automatic merge_run();
    int          n_subs;
    int          n_most;
    int          i;
    logic [32:0] sum;
    n_subs = (run_inserts < run_deletes) ? run_inserts : run_deletes;
    n_most = (run_inserts > run_deletes) ? run_inserts : run_deletes;
    if (run_overflowed) overflow_runs++;
    for (i = 0; i < n_subs; i++)
      add_result(CMD_SUBST, {24'd0, run_chars[i]}, run_overflowed);
    if (run_inserts > run_deletes) begin
      for (i = n_subs; i < run_inserts; i++)
        add_result(CMD_INSERT, {24'd0, run_chars[i]}, run_overflowed);
    end else begin
      for (i = n_subs; i < run_deletes; i++)
        add_result(CMD_DELETE, DELETE_MARK, run_overflowed);
    end
    sum = {1'b0, script_distance} + 33'(n_most);
    script_distance = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    run_inserts    = '0;
    run_deletes    = '0;
    run_overflowed = 1'b0;
  endtask

  // Work out the result words caused by one accepted edit word.
  task automatic predict_edit(in_word_t w);
    int        n_before;
    int        n_after;
    out_word_t tail;
    n_before = pending_results.size();
    case (w.command)
      CMD_SAME: begin
        merge_run();
        add_result(CMD_SAME, w.edit_value, 1'b0);
      end
      CMD_INSERT: begin
        if (run_inserts < RUN_DEPTH) begin
          run_chars[run_inserts] = w.edit_value[7:0];
          run_inserts++;
        end else begin
          run_overflowed = 1'b1;
        end
      end
      CMD_DELETE, CMD_SUBST: begin
        if (run_deletes < RUN_DEPTH) run_deletes++;
        else run_overflowed = 1'b1;
      end
      CMD_END: begin
        merge_run();
        add_result(CMD_END, script_distance, 1'b0);
        script_distance = '0;
      end
      default: ;  // unused commands leave everything alone
    endcase
    // Flag the final word this edit caused.
    n_after = pending_results.size();
    if (n_after > n_before) begin
      tail = pending_results[n_after - 1];
      tail.last_result = 1'b1;
      pending_results[n_after - 1] = tail;
    end
  endtask

  // Send one edit word. Call and return at a falling edge; valid stays high
  // after acceptance so the next word can follow without a gap.
  task automatic send_edit(logic [2:0] cmd, logic [31:0] value);
    in_word_t w;
    w.command    = cmd;
    w.edit_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_edit(w);
    if (cmd <= CMD_END) edit_words++;
    @(negedge clk);
  endtask

  // Hold the receiver back at random; sampled by the block at the next rise.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result word with the oldest one owed.
  always @(posedge clk) begin
    out_word_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word kind %0d value %h ovf %b last %b", $time,
                 out_data.out_kind, out_data.out_value, out_data.run_overflow,
                 out_data.last_result);
        err_count++;
      end else begin
        exp_word = pending_results.pop_front();
        results_checked++;
        if (out_data.out_kind !== exp_word.out_kind ||
            out_data.out_value !== exp_word.out_value ||
            out_data.run_overflow !== exp_word.run_overflow ||
            out_data.last_result !== exp_word.last_result) begin
          $display("%0t: mismatch: expected kind %0d value %h ovf %b last %b", $time,
                   exp_word.out_kind, exp_word.out_value, exp_word.run_overflow,
                   exp_word.last_result);
          $display("%0t:           actual   kind %0d value %h ovf %b last %b", $time,
                   out_data.out_kind, out_data.out_value, out_data.run_overflow,
                   out_data.last_result);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, pending_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Extremes of the fields, every command, unused commands, runs with more
  // inserts and with more deletes, and empty runs.
  task automatic test_directed();
    send_edit(CMD_SAME, 32'h0000_0000);          // empty run closed by same
    send_edit(CMD_SAME, 32'hFFFF_FFFF);
    send_edit(CMD_INSERT, 32'h0000_0000);
    send_edit(CMD_INSERT, 32'hFFFF_FFFF);        // only the low byte is kept
    send_edit(CMD_DELETE, 32'hFFFF_FFFF);
    send_edit(CMD_SUBST, 32'h0000_0000);         // counts as a delete
    send_edit(CMD_UNUSED_LO, 32'hFFFF_FFFF);
    send_edit(CMD_SAME, 32'h0000_0001);          // two substitutions
    send_edit(CMD_INSERT, 32'h1234_5641);
    send_edit(CMD_INSERT, 32'hA5A5_A542);
    send_edit(CMD_INSERT, 32'h5A5A_5A43);
    send_edit(CMD_DELETE, 32'h0000_0000);
    send_edit(CMD_UNUSED_LO + 3'd1, 32'h0);
    send_edit(CMD_END, 32'hFFFF_FFFF);           // leftover inserts, report 5
    send_edit(CMD_INSERT, 32'h0000_0080);
    send_edit(CMD_DELETE, 32'h0000_0000);
    send_edit(CMD_SUBST, 32'hFFFF_FFFF);
    send_edit(CMD_DELETE, 32'h8000_0000);
    send_edit(CMD_UNUSED_HI, 32'h5555_5555);
    send_edit(CMD_SAME, 32'h8000_0000);          // leftover deletes
    send_edit(CMD_END, 32'h0000_0000);           // report 3
    send_edit(CMD_END, 32'h0000_0000);           // empty script, report 0
  endtask

  // Overfill both counters in one run: drops past the buffer depth, the
  // overflow flag on every replayed word, and the longest replay.
  task automatic test_overflow();
    int i;
    for (i = 0; i < RUN_DEPTH + 2; i++) send_edit(CMD_INSERT, $urandom);
    for (i = 0; i < RUN_DEPTH + 3; i++)
      send_edit((i % 2 == 0) ? CMD_DELETE : CMD_SUBST, $urandom);
    send_edit(CMD_END, $urandom);
  endtask

  // One well-formed run with random content: interleaved inserts and
  // deletes, a little noise, closed by a same or an end word.
  task automatic send_random_run();
    int ins_left;
    int del_left;
    if ($urandom_range(11) == 0) begin
      ins_left = $urandom_range(RUN_DEPTH - 4, RUN_DEPTH + 8);
      del_left = $urandom_range(0, RUN_DEPTH + 8);
    end else begin
      ins_left = $urandom_range(0, 5);
      del_left = $urandom_range(0, 5);
    end
    while (ins_left + del_left > 0) begin
      if ($urandom_range(15) == 0)
        send_edit(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom);
      if (ins_left > 0 && (del_left == 0 || $urandom_range(1) == 0)) begin
        send_edit(CMD_INSERT, $urandom);
        ins_left--;
      end else begin
        send_edit($urandom_range(1) ? CMD_DELETE : CMD_SUBST, $urandom);
        del_left--;
      end
    end
    send_edit(($urandom_range(3) == 0) ? CMD_END : CMD_SAME, $urandom);
  endtask

  // Random runs until about word_goal edit words have been taken.
  task automatic test_random(int word_goal);
    int start_words;
    start_words = edit_words;
    while (edit_words - start_words < word_goal) send_random_run();
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    send_idle_pct   = 31;
    recv_idle_pct   = 57;
    err_count       = 0;
    edit_words      = 0;
    results_checked = 0;
    overflow_runs   = 0;
    idle_cycles     = 0;
    run_inserts     = '0;
    run_deletes     = '0;
    script_distance = '0;
    run_overflowed  = 1'b0;
    foreach (run_chars[i]) run_chars[i] = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender slow, receiver slower.
    test_directed();
    test_overflow();
    test_random(10);
    // Swap the idle rates.
    send_idle_pct = 57;
    recv_idle_pct = 31;
    test_random(10);
    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(10);

    // Drop valid, drain what is owed, then let the block settle.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d edit words and %0d result words, %0d runs past the buffer.",
             edit_words, results_checked, overflow_runs);
    $display("Idle phases: sender/receiver 31/57, 57/31, then none; %0d mismatches.",
             err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
